>>> rtl/dscf_pkg.sv
// Shared constants for the direct-sum Coulomb field block.
// No dependencies; used by the top level only.
package dscf_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PARTICLE_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN_DISTANCE   = 2'd1;
    localparam logic [1:0] REG_COULOMB_SCALE  = 2'd2;

    // transaction kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int  COUNT_W = 11;
    localparam int  CFG_W   = 32;
    localparam int  FIELD_W = 48;

    // clamp limits
    localparam logic [48:0]        TERM_LIM = 49'h1_0000_0000_0000;
    localparam logic signed [63:0] ACC_LIM  = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] OUT_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN  = 64'shFFFF_8000_0000_0000;

endpackage

>>> rtl/direct_sum_coulomb_field.sv
// Direct-sum Coulomb field: a query sums over n = min(particle_count, MAX) sources,
// skipping the divide for an axis whose distance or whose source charge is zero.
// All multiply, root and divide steps run bit-serially through one shared adder.
// Loads write the particle memories; busy is high for the whole query; done pulses one cycle.
// Reset (async, rst_n low) idles the sequencer and restores the register defaults.
module direct_sum_coulomb_field #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COORD_BITS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic [9:0]          index,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  charge,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [31:0]         wr_data,
    output logic                done,
    output logic signed [47:0]  field_x,
    output logic signed [47:0]  field_y,
    output logic signed [47:0]  field_z,
    output logic                saturated
);

    localparam int CB   = COORD_BITS;
    localparam int DB   = CB + 1;
    localparam int RB   = (CB + 1 > 32) ? CB + 1 : 32;
    localparam int R2B  = 2 * RB;
    localparam int R3B  = 3 * RB;
    localparam int NB   = 80 + DB;
    localparam int W    = (R3B + 1 > 64 + DB) ? R3B + 1 : 64 + DB;
    localparam int MPW  = (RB > DB) ? RB : DB;
    localparam int AW   = $clog2(MAX_PARTICLES);
    localparam int CW   = AW + 1;
    localparam int CNTW = $clog2(NB + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TGT  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_SRC  = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_RR   = 4'd6;
    localparam logic [3:0] S_RRR  = 4'd7;
    localparam logic [3:0] S_AX   = 4'd8;
    localparam logic [3:0] S_NQ   = 4'd9;
    localparam logic [3:0] S_ND   = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_ACC  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    // control
    logic [3:0]   state_reg, state_next;
    logic         done_reg, done_next;
    logic [dscf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [31:0]  mind_reg, mind_next;
    logic [31:0]  scale_reg, scale_next;

    // datapath
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [1:0]      axis_reg, axis_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic signed [CB-1:0] t_reg [3];
    logic signed [CB-1:0] t_next [3];
    logic signed [DB-1:0] d_reg [3];
    logic signed [DB-1:0] d_next [3];
    logic [DB-1:0]   dmag_reg [3];
    logic [DB-1:0]   dmag_next [3];
    logic signed [31:0] q_reg, q_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    mc_reg, mc_next;
    logic [MPW-1:0]  mp_reg, mp_next;
    logic [R2B-1:0]  v_reg, v_next;
    logic [RB-1:0]   root_reg, root_next;
    logic [RB-1:0]   r_reg, r_next;
    logic [R3B-1:0]  den_reg, den_next;
    logic [NB-1:0]   dvd_reg, dvd_next;
    logic [NB-1:0]   quo_reg, quo_next;
    logic signed [63:0] f_reg [3];
    logic signed [63:0] f_next [3];
    logic            flag_reg, flag_next;
    logic signed [47:0] fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic            sat_reg, sat_next;

    // memories
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [CB-1:0]   rd_x, rd_y, rd_z;
    logic [31:0]     rd_q;
    logic            in_range;

    // shared unit
    logic [W-1:0]    alu_a, alu_b, alu_y;
    logic            alu_sub, alu_co;
    logic [W-1:0]    mult_y;
    logic [RB+2:0]   rem_sh_s;

    assign in_range = (32'(index) < 32'(MAX_PARTICLES));
    assign mem_we   = (state_reg == S_IDLE) && start && (kind == dscf_pkg::KIND_LOAD) && in_range;
    assign mem_addr = (state_reg == S_IDLE) ? AW'(index) : j_reg[AW-1:0];

    dscf_ram #(.WIDTH(CB), .DEPTH(MAX_PARTICLES)) u_ram_x (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(CB'(pos_x)), .rdata(rd_x));
    dscf_ram #(.WIDTH(CB), .DEPTH(MAX_PARTICLES)) u_ram_y (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(CB'(pos_y)), .rdata(rd_y));
    dscf_ram #(.WIDTH(CB), .DEPTH(MAX_PARTICLES)) u_ram_z (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(CB'(pos_z)), .rdata(rd_z));
    dscf_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_ram_q (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(charge), .rdata(rd_q));

    assign rem_sh_s = {acc_reg[RB:0], v_reg[R2B-1:R2B-2]};

    always_comb
    begin
        case (state_reg)
            S_SQRT:
            begin
                alu_a   = W'(rem_sh_s);
                alu_b   = W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {acc_reg[W-2:0], dvd_reg[NB-1]};
                alu_b   = W'(den_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = mc_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    dscf_alu #(.W(W)) u_alu (
        .a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y), .co(alu_co));

    assign mult_y = mp_reg[0] ? alu_y : acc_reg;

    always_comb
    begin
        logic [RB-1:0]       root_f;
        logic [RB-1:0]       r_f;
        logic [NB-1:0]       quo_f;
        logic [48:0]         term;
        logic signed [63:0]  sum;
        logic                last;
        logic [CB:0]         diff;
        logic                next_src;

        state_next = state_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        mind_next  = mind_reg;
        scale_next = scale_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        d_next     = d_reg;
        dmag_next  = dmag_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        mc_next    = mc_reg;
        mp_next    = mp_reg;
        v_next     = v_reg;
        root_next  = root_reg;
        r_next     = r_reg;
        den_next   = den_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        f_next     = f_reg;
        flag_next  = flag_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        fz_next    = fz_reg;
        sat_next   = sat_reg;
        root_f     = '0;
        r_f        = '0;
        quo_f      = '0;
        term       = '0;
        sum        = '0;
        diff       = '0;
        next_src   = 1'b0;
        last       = (cnt_reg == CNTW'(1));

        if (wr_en)
        begin
            case (wr_index)
                dscf_pkg::REG_PARTICLE_COUNT: count_next = wr_data[dscf_pkg::COUNT_W-1:0];
                dscf_pkg::REG_MIN_DISTANCE:   mind_next  = wr_data;
                dscf_pkg::REG_COULOMB_SCALE:  scale_next = wr_data;
                default: ;
            endcase
        end

        // bit-serial multiply: shift multiplicand left, multiplier right
        if (state_reg == S_SQ || state_reg == S_RR || state_reg == S_RRR ||
            state_reg == S_NQ || state_reg == S_ND)
        begin
            acc_next = mult_y;
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - CNTW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy && kind == dscf_pkg::KIND_QUERY)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        f_next[a] = '0;
                    end
                    flag_next = 1'b0;
                    j_next    = '0;
                    n_next    = (32'(count_reg) < 32'(MAX_PARTICLES)) ?
                                CW'(count_reg) : CW'(MAX_PARTICLES);
                    if (!in_range || count_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_TGT;
                    end
                end
            end
            S_TGT:
            begin
                t_next[0]  = rd_x;
                t_next[1]  = rd_y;
                t_next[2]  = rd_z;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_SRC;
            end
            S_SRC:
            begin
                diff = {t_reg[0][CB-1], t_reg[0]} - {rd_x[CB-1], rd_x};
                d_next[0] = DB'(signed'(diff));
                diff = {t_reg[1][CB-1], t_reg[1]} - {rd_y[CB-1], rd_y};
                d_next[1] = DB'(signed'(diff));
                diff = {t_reg[2][CB-1], t_reg[2]} - {rd_z[CB-1], rd_z};
                d_next[2] = DB'(signed'(diff));
                for (int a = 0; a < 3; a++)
                begin
                    dmag_next[a] = d_next[a][DB-1] ? DB'(-d_next[a]) : DB'(d_next[a]);
                end
                q_next     = signed'(rd_q);
                acc_next   = '0;
                mc_next    = W'(dmag_next[0]);
                mp_next    = MPW'(dmag_next[0]);
                cnt_next   = CNTW'(DB);
                axis_next  = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (last)
                begin
                    if (axis_reg != 2'd2)
                    begin
                        axis_next = axis_reg + 2'd1;
                        mc_next   = W'(dmag_reg[axis_next]);
                        mp_next   = MPW'(dmag_reg[axis_next]);
                        cnt_next  = CNTW'(DB);
                    end
                    else
                    begin
                        v_next     = mult_y[R2B-1:0];
                        acc_next   = '0;
                        root_next  = '0;
                        cnt_next   = CNTW'(RB);
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                if (!alu_co)
                begin
                    acc_next = alu_y;
                    root_f   = {root_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    acc_next = W'(rem_sh_s);
                    root_f   = {root_reg[RB-2:0], 1'b0};
                end
                root_next = root_f;
                v_next    = v_reg << 2;
                cnt_next  = cnt_reg - CNTW'(1);
                if (last)
                begin
                    r_f = (root_f < RB'(mind_reg)) ? RB'(mind_reg) : root_f;
                    if (r_f == '0)
                    begin
                        next_src = 1'b1;
                    end
                    else
                    begin
                        r_next     = r_f;
                        acc_next   = '0;
                        mc_next    = W'(r_f);
                        mp_next    = MPW'(r_f);
                        cnt_next   = CNTW'(RB);
                        state_next = S_RR;
                    end
                end
            end
            S_RR:
            begin
                if (last)
                begin
                    mc_next    = mult_y;
                    mp_next    = MPW'(r_reg);
                    acc_next   = '0;
                    cnt_next   = CNTW'(RB);
                    state_next = S_RRR;
                end
            end
            S_RRR:
            begin
                if (last)
                begin
                    den_next   = mult_y[R3B-1:0];
                    axis_next  = 2'd0;
                    state_next = S_AX;
                end
            end
            S_AX:
            begin
                if (dmag_reg[axis_reg] == '0 || q_reg == '0)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        next_src = 1'b1;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    acc_next   = '0;
                    mc_next    = W'(scale_reg);
                    mp_next    = MPW'(q_reg[31] ? 32'(-q_reg) : 32'(q_reg));
                    cnt_next   = CNTW'(32);
                    state_next = S_NQ;
                end
            end
            S_NQ:
            begin
                if (last)
                begin
                    mc_next    = mult_y;
                    mp_next    = MPW'(dmag_reg[axis_reg]);
                    acc_next   = '0;
                    cnt_next   = CNTW'(DB);
                    state_next = S_ND;
                end
            end
            S_ND:
            begin
                if (last)
                begin
                    dvd_next   = {mult_y[NB-17:0], 16'b0};
                    acc_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CNTW'(NB);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!alu_co)
                begin
                    acc_next = alu_y;
                    quo_f    = {quo_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    acc_next = alu_a;
                    quo_f    = {quo_reg[NB-2:0], 1'b0};
                end
                quo_next = quo_f;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CNTW'(1);
                if (last)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (quo_reg > NB'(dscf_pkg::TERM_LIM))
                begin
                    term      = dscf_pkg::TERM_LIM;
                    flag_next = 1'b1;
                end
                else
                begin
                    term = quo_reg[48:0];
                end
                if (d_reg[axis_reg][DB-1] != q_reg[31])
                begin
                    sum = f_reg[axis_reg] - signed'({15'b0, term});
                end
                else
                begin
                    sum = f_reg[axis_reg] + signed'({15'b0, term});
                end
                if (sum > dscf_pkg::ACC_LIM)
                begin
                    sum       = dscf_pkg::ACC_LIM;
                    flag_next = 1'b1;
                end
                else if (sum < -dscf_pkg::ACC_LIM)
                begin
                    sum       = -dscf_pkg::ACC_LIM;
                    flag_next = 1'b1;
                end
                f_next[axis_reg] = sum;
                if (axis_reg == 2'd2)
                begin
                    next_src = 1'b1;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_AX;
                end
            end
            S_FIN:
            begin
                sat_next = flag_reg;
                for (int a = 0; a < 3; a++)
                begin
                    sum = f_reg[a];
                    if (sum > dscf_pkg::OUT_MAX)
                    begin
                        sum      = dscf_pkg::OUT_MAX;
                        sat_next = 1'b1;
                    end
                    else if (sum < dscf_pkg::OUT_MIN)
                    begin
                        sum      = dscf_pkg::OUT_MIN;
                        sat_next = 1'b1;
                    end
                    case (a)
                        0:       fx_next = sum[47:0];
                        1:       fy_next = sum[47:0];
                        default: fz_next = sum[47:0];
                    endcase
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // move on to the next source, or finish after the last one
        if (next_src)
        begin
            j_next = j_reg + CW'(1);
            if (j_next == n_reg)
            begin
                state_next = S_FIN;
            end
            else
            begin
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= dscf_pkg::COUNT_W'(1);
            mind_reg  <= '0;
            scale_reg <= 32'h0001_0000;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            mind_reg  <= mind_next;
            scale_reg <= scale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        j_reg    <= j_next;
        axis_reg <= axis_next;
        cnt_reg  <= cnt_next;
        t_reg    <= t_next;
        d_reg    <= d_next;
        dmag_reg <= dmag_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        mc_reg   <= mc_next;
        mp_reg   <= mp_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        r_reg    <= r_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        f_reg    <= f_next;
        flag_reg <= flag_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        fz_reg   <= fz_next;
        sat_reg  <= sat_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign field_x   = fx_reg;
    assign field_y   = fy_reg;
    assign field_z   = fz_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/dscf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dscf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/dscf_alu.sv
// Shared wide add/subtract unit used by the multiply, root and divide steps.
// No dependencies.
module dscf_alu #(
    parameter int W = 100
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] y,
    output logic         co
);

    logic [W:0] full;

    always_comb
    begin
        if (sub)
        begin
            full = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign y  = full[W-1:0];
    assign co = full[W];   // borrow when subtracting

endmodule
